// ===== src/mvw_pkg.sv =====
// Shared constants, types and compare functions for the mesh vertex welder.
// Used by the controller, the datapath and the top level; depends on nothing.
package mvw_pkg;

    localparam int MAX_CORNERS         = 4096;
    localparam int MAX_SOURCE_VERTICES = 4096;
    localparam int MAX_CHANNELS        = 4;

    localparam int IDX_W  = $clog2(MAX_CORNERS);
    localparam int CNT_W  = $clog2(MAX_CORNERS + 1);
    localparam int VTX_W  = 12;
    localparam int GRP_W  = 32;
    localparam int UV_W   = 64 * MAX_CHANNELS;
    localparam int CHN_W  = 3;
    localparam int OP_W   = 3;
    localparam int ROW_W  = UV_W + GRP_W + VTX_W;
    localparam int IN_W   = 320;
    localparam int OUT_W  = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_COMPUTE = 3'd1;
    localparam logic [OP_W-1:0] OP_RDSLOT  = 3'd2;
    localparam logic [OP_W-1:0] OP_RDREP   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // Datapath command codes.
    localparam logic [3:0] C_NONE   = 4'd0;
    localparam logic [3:0] C_ACCEPT = 4'd1;
    localparam logic [3:0] C_RDDONE = 4'd2;
    localparam logic [3:0] C_CLRM   = 4'd3;
    localparam logic [3:0] C_PINIT  = 4'd4;
    localparam logic [3:0] C_JRD    = 4'd5;
    localparam logic [3:0] C_JEV    = 4'd6;
    localparam logic [3:0] C_KRD    = 4'd7;
    localparam logic [3:0] C_KEV    = 4'd8;
    localparam logic [3:0] C_SCLOSE = 4'd9;
    localparam logic [3:0] C_NEXTV  = 4'd10;
    localparam logic [3:0] C_CDONE  = 4'd11;

    typedef struct packed {
        logic [3:0] code;
    } t_cmd;

    typedef struct packed {
        logic j_end;
        logic k_end;
        logic open_slot;
        logic next_found;
        logic rd_err;
        logic out_busy;
    } t_status;

    // IEEE single equality: NaN never matches, +0 equals -0.
    function automatic logic single_equal(input logic [31:0] a, input logic [31:0] b);
        logic nan_any;
        nan_any = (a[30:0] > 31'h7F80_0000) || (b[30:0] > 31'h7F80_0000);
        return !nan_any && ((a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)));
    endfunction

    // Compare the channels in use of two UV rows.
    function automatic logic uv_match(input logic [UV_W-1:0] a, input logic [UV_W-1:0] b,
                                      input logic [CHN_W-1:0] chans);
        logic ok;
        ok = 1'b1;
        for (int t = 0; t < MAX_CHANNELS; t++) begin
            if (t < int'(chans)) begin
                ok = ok && single_equal(a[64*t +: 32], b[64*t +: 32])
                        && single_equal(a[64*t+32 +: 32], b[64*t+32 +: 32]);
            end
        end
        return ok;
    endfunction

endpackage

// ===== src/mvw_ctrl.sv =====
// Sequencer of the mesh vertex welder: accepts beats and steps the compute walk.
// Depends on mvw_pkg; drives the datapath through t_cmd and reads t_status.
module mvw_ctrl
    import mvw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_op,
    input  t_status         i_status,
    output logic            o_in_ready,
    output t_cmd            o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_CLR    = 3'd2;
    localparam logic [2:0] S_JRD    = 3'd3;
    localparam logic [2:0] S_JEV    = 3'd4;
    localparam logic [2:0] S_KRD    = 3'd5;
    localparam logic [2:0] S_KEV    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE) && !i_status.out_busy;
    assign accept     = i_in_valid && o_in_ready;

    // Next state and command.
    always_comb begin
        n_state    = r_state;
        o_cmd.code = C_NONE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.code = C_ACCEPT;
                    if (i_op == OP_COMPUTE) begin
                        n_state = S_CLR;
                    end else if ((i_op == OP_RDSLOT || i_op == OP_RDREP)
                                 && !i_status.rd_err) begin
                        n_state = S_RDWAIT;
                    end
                end
            end
            S_RDWAIT: begin
                o_cmd.code = C_RDDONE;
                n_state    = S_IDLE;
            end
            S_CLR: begin
                if (i_status.j_end) begin
                    o_cmd.code = C_PINIT;
                    n_state    = S_JRD;
                end else begin
                    o_cmd.code = C_CLRM;
                end
            end
            S_JRD: begin
                if (i_status.j_end) begin
                    if (i_status.next_found) begin
                        o_cmd.code = C_NEXTV;
                    end else begin
                        o_cmd.code = C_CDONE;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.code = C_JRD;
                    n_state    = S_JEV;
                end
            end
            S_JEV: begin
                o_cmd.code = C_JEV;
                n_state    = i_status.open_slot ? S_KRD : S_JRD;
            end
            S_KRD: begin
                if (i_status.k_end) begin
                    o_cmd.code = C_SCLOSE;
                    n_state    = S_JRD;
                end else begin
                    o_cmd.code = C_KRD;
                    n_state    = S_KEV;
                end
            end
            S_KEV: begin
                o_cmd.code = C_KEV;
                n_state    = S_KRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/mvw_dp.sv =====
// Datapath of the mesh vertex welder: corner, merge, slot and representative memories,
// loop counters, compare logic and the result register. Depends on mvw_pkg.
module mvw_dp
    import mvw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [IN_W-1:0]  i_data,
    input  logic             i_cfg_we,
    input  logic [CHN_W-1:0] i_cfg_data,
    input  logic             i_out_ready,
    output t_status          o_status,
    output logic             o_out_valid,
    output logic [OUT_W-1:0] o_out_data
);

    // Input beat fields.
    logic [OP_W-1:0]  in_op;
    logic [VTX_W-1:0] in_vtx;
    logic [GRP_W-1:0] in_grp;
    logic [UV_W-1:0]  in_uv;
    logic [IDX_W-1:0] in_idx;

    assign in_op  = i_data[2:0];
    assign in_vtx = i_data[14:3];
    assign in_grp = i_data[46:15];
    assign in_uv  = i_data[302:47];
    assign in_idx = i_data[314:303];

    // Memories.
    logic [ROW_W-1:0] m_corner [MAX_CORNERS];
    logic             m_merged [MAX_CORNERS];
    logic [IDX_W-1:0] m_slot   [MAX_CORNERS];
    logic [IDX_W-1:0] m_rep    [MAX_CORNERS];

    logic [CNT_W-1:0] r_cc;
    logic [CNT_W-1:0] r_uc;
    logic             r_computed;
    logic [CHN_W-1:0] r_chans;
    logic [CNT_W-1:0] r_j;
    logic [CNT_W-1:0] r_k;
    logic [VTX_W-1:0] r_v;
    logic             r_vvalid;
    logic [VTX_W-1:0] r_nv;
    logic             r_nf;
    logic [GRP_W-1:0] r_ref_grp;
    logic [UV_W-1:0]  r_ref_uv;
    logic [ROW_W-1:0] r_crd;
    logic             r_mrd;
    logic [IDX_W-1:0] r_slot_rd;
    logic [IDX_W-1:0] r_rep_rd;
    logic             r_rd_rep;
    logic             r_ovalid;
    logic [CNT_W-1:0] r_oval;
    logic             r_oerr;

    logic [CHN_W-1:0] chans_eff;
    logic [VTX_W-1:0] rd_vtx;
    logic [GRP_W-1:0] rd_grp;
    logic [UV_W-1:0]  rd_uv;
    logic             j_hit;
    logic             k_hit;
    logic             nv_cand;
    logic             load_err;
    logic             rd_err;
    logic [CNT_W-1:0] idx_ext;
    logic [IDX_W-1:0] rd_addr;
    logic             is_accept;

    assign is_accept = (i_cmd.code == C_ACCEPT);

    // Channel count clamped to the stored range.
    always_comb begin
        if (r_chans == '0) begin
            chans_eff = CHN_W'(1);
        end else if (r_chans > CHN_W'(MAX_CHANNELS)) begin
            chans_eff = CHN_W'(MAX_CHANNELS);
        end else begin
            chans_eff = r_chans;
        end
    end

    assign rd_vtx  = r_crd[VTX_W-1:0];
    assign rd_grp  = r_crd[VTX_W +: GRP_W];
    assign rd_uv   = r_crd[VTX_W+GRP_W +: UV_W];

    // Slot opening and merge decisions on the registered read beat.
    assign j_hit   = r_vvalid && (rd_vtx == r_v) && !r_mrd;
    assign k_hit   = (rd_vtx == r_v) && !r_mrd && (rd_grp == r_ref_grp)
                     && uv_match(r_ref_uv, rd_uv, chans_eff);
    assign nv_cand = (!r_vvalid || rd_vtx > r_v) && (!r_nf || rd_vtx < r_nv);

    // Refusal checks for the beat on the input.
    assign idx_ext  = CNT_W'(in_idx);
    assign load_err = (r_cc >= CNT_W'(MAX_CORNERS))
                      || ({1'b0, in_vtx} >= (VTX_W+1)'(MAX_SOURCE_VERTICES));
    always_comb begin
        case (in_op)
            OP_RDSLOT: rd_err = !r_computed || (idx_ext >= r_cc);
            OP_RDREP:  rd_err = !r_computed || (idx_ext >= r_uc);
            default:   rd_err = 1'b0;
        endcase
    end

    assign o_status.j_end      = (r_j == r_cc);
    assign o_status.k_end      = (r_k == r_cc);
    assign o_status.open_slot  = j_hit;
    assign o_status.next_found = r_nf;
    assign o_status.rd_err     = rd_err;
    assign o_status.out_busy   = r_ovalid;

    assign rd_addr = (i_cmd.code == C_KRD) ? r_k[IDX_W-1:0] : r_j[IDX_W-1:0];

    // Corner store: written by loads, read during the walk.
    always_ff @(posedge i_clk) begin
        if (is_accept && in_op == OP_LOAD && !load_err) begin
            m_corner[r_cc[IDX_W-1:0]] <= {in_uv, in_grp, in_vtx};
        end
        if (i_cmd.code == C_JRD || i_cmd.code == C_KRD) begin
            r_crd <= m_corner[rd_addr];
        end
    end

    // Merge flags: cleared at compute start, set on a match.
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == C_CLRM) begin
            m_merged[r_j[IDX_W-1:0]] <= 1'b0;
        end else if (i_cmd.code == C_KEV && k_hit) begin
            m_merged[r_k[IDX_W-1:0]] <= 1'b1;
        end
        if (i_cmd.code == C_JRD || i_cmd.code == C_KRD) begin
            r_mrd <= m_merged[rd_addr];
        end
    end

    // Corner slot table.
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == C_JEV && j_hit) begin
            m_slot[r_j[IDX_W-1:0]] <= r_uc[IDX_W-1:0];
        end else if (i_cmd.code == C_KEV && k_hit) begin
            m_slot[r_k[IDX_W-1:0]] <= r_uc[IDX_W-1:0];
        end
        if (is_accept) begin
            r_slot_rd <= m_slot[in_idx];
        end
    end

    // Slot representative table.
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == C_JEV && j_hit) begin
            m_rep[r_uc[IDX_W-1:0]] <= r_j[IDX_W-1:0];
        end
        if (is_accept) begin
            r_rep_rd <= m_rep[in_idx];
        end
    end

    // Reference corner of the open slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == C_JEV && j_hit) begin
            r_ref_grp <= rd_grp;
            r_ref_uv  <= rd_uv;
        end
        if (is_accept) begin
            r_rd_rep <= (in_op == OP_RDREP);
        end
    end

    // Counts, walk counters and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc       <= '0;
            r_uc       <= '0;
            r_computed <= 1'b0;
            r_chans    <= CHN_W'(1);
            r_j        <= '0;
            r_k        <= '0;
            r_v        <= '0;
            r_vvalid   <= 1'b0;
            r_nv       <= '0;
            r_nf       <= 1'b0;
            r_ovalid   <= 1'b0;
            r_oval     <= '0;
            r_oerr     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_chans <= i_cfg_data;
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.code)
                C_ACCEPT: begin
                    r_oval <= '0;
                    r_oerr <= 1'b0;
                    case (in_op)
                        OP_LOAD: begin
                            r_ovalid <= 1'b1;
                            if (load_err) begin
                                r_oerr <= 1'b1;
                            end else begin
                                r_oval     <= r_cc;
                                r_cc       <= r_cc + CNT_W'(1);
                                r_computed <= 1'b0;
                            end
                        end
                        OP_COMPUTE: begin
                            r_j <= '0;
                        end
                        OP_RDSLOT, OP_RDREP: begin
                            if (rd_err) begin
                                r_ovalid <= 1'b1;
                                r_oerr   <= 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            r_ovalid   <= 1'b1;
                            r_cc       <= '0;
                            r_uc       <= '0;
                            r_computed <= 1'b0;
                        end
                        default: begin
                            r_ovalid <= 1'b1;
                        end
                    endcase
                end
                C_RDDONE: begin
                    r_ovalid <= 1'b1;
                    r_oval   <= CNT_W'(r_rd_rep ? r_rep_rd : r_slot_rd);
                end
                C_CLRM: begin
                    r_j <= r_j + CNT_W'(1);
                end
                C_PINIT: begin
                    r_j      <= '0;
                    r_uc     <= '0;
                    r_vvalid <= 1'b0;
                    r_nf     <= 1'b0;
                end
                C_JEV: begin
                    if (nv_cand) begin
                        r_nv <= rd_vtx;
                        r_nf <= 1'b1;
                    end
                    if (j_hit) begin
                        r_k <= r_j + CNT_W'(1);
                    end else begin
                        r_j <= r_j + CNT_W'(1);
                    end
                end
                C_KEV: begin
                    r_k <= r_k + CNT_W'(1);
                end
                C_SCLOSE: begin
                    r_uc <= r_uc + CNT_W'(1);
                    r_j  <= r_j + CNT_W'(1);
                end
                C_NEXTV: begin
                    r_v      <= r_nv;
                    r_vvalid <= 1'b1;
                    r_nf     <= 1'b0;
                    r_j      <= '0;
                end
                C_CDONE: begin
                    r_computed <= 1'b1;
                    r_ovalid   <= 1'b1;
                    r_oval     <= r_uc;
                    r_oerr     <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {2'b00, r_oerr, r_oval};

endmodule

// ===== src/mesh_vertex_welder_core.sv =====
// Top level of the mesh vertex welder: stream ports, configuration port, assertions.
// Depends on mvw_pkg, mvw_ctrl and mvw_dp.

// The block takes one beat at a time and returns exactly one result beat for it.
// Load, clear and refused requests answer in the cycle after acceptance; reads register the
// table entry at acceptance and then register their result in the S_RDWAIT state.
// Compute walks the corner store: a clearing sweep over the N corners loaded, then for
// each distinct source vertex V_d plus one initial pass, a pass over all corners, and
// for every opened slot a scan over every later corner; the walk is paced by the single
// read port of the corner memory. The next beat is taken once the result has been taken.
module mesh_vertex_welder_core
    import mvw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // operation, source_vertex, smoothing_group, u_first, v_first, u_second,
    // v_second, u_third, v_third, u_fourth, v_fourth, read_index; zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // result_value, error_flag; zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CHN_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    mvw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tdata[OP_W-1:0]),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // Storage and compare logic.
    mvw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data      (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // A pending result blocks new input beats.
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    // After an accepted beat the block is not ready in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after acceptance");

    // A refused request carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |-> (m_axis_tdata[12:0] == 13'd0))
        else $error("error result with nonzero value");
`endif

endmodule

// ===== tb/sv/tb_mesh_vertex_welder_core.sv =====
// Self-checking testbench for mesh_vertex_welder_core: drives load, compute, read and
// clear beats, predicts every result beat and checks it. Depends on mvw_pkg and the RTL.
module tb_mesh_vertex_welder_core;
    import mvw_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CHN_W-1:0] i_cfg_data;

    mesh_vertex_welder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct {
        logic [12:0] value;
        logic        err;
    } t_answer;

    // Shadow copy of the welder state.
    logic [11:0]  sh_vtx   [MAX_CORNERS];
    logic [31:0]  sh_grp   [MAX_CORNERS];
    logic [255:0] sh_uv    [MAX_CORNERS];
    logic [11:0]  sh_slot  [MAX_CORNERS];
    logic [11:0]  sh_rep   [MAX_CORNERS];
    int           sh_corners;
    int           sh_uniques;
    bit           sh_computed;
    logic [2:0]   sh_chans;

    t_answer answers_due[$];
    int      fail_count;
    int      beats_sent;
    int      beats_checked;
    int      computes_sent;

    // Clock generation.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic bit float_same(input logic [31:0] a, input logic [31:0] b);
        if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000) return 1'b0;
        return (a == b) || (a[30:0] == 0 && b[30:0] == 0);
    endfunction

    function automatic bit corners_weld(input int a, input int b, input int chans);
        if (sh_grp[a] != sh_grp[b]) return 1'b0;
        for (int t = 0; t < chans; t++) begin
            if (!float_same(sh_uv[a][64*t +: 32], sh_uv[b][64*t +: 32])) return 1'b0;
            if (!float_same(sh_uv[a][64*t+32 +: 32], sh_uv[b][64*t+32 +: 32])) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Weld pass: vertices ascending, corners in load order within a vertex.
    function automatic void weld_corners();
        int chans;
        int order[$];
        bit merged[$];
        int vlist[$];
        chans = (sh_chans == 0) ? 1 : (sh_chans > MAX_CHANNELS ? MAX_CHANNELS : sh_chans);
        for (int i = 0; i < sh_corners; i++) vlist.insert(vlist.size(), sh_vtx[i]);
        vlist = vlist.unique();
        vlist.sort();
        foreach (vlist[n]) begin
            for (int i = 0; i < sh_corners; i++)
                if (sh_vtx[i] == vlist[n]) order.insert(order.size(), i);
        end
        foreach (order[j]) merged.insert(merged.size(), 1'b0);
        sh_uniques = 0;
        for (int j = 0; j < order.size(); j++) begin
            if (merged[j]) continue;
            sh_rep[sh_uniques] = 12'(order[j]);
            sh_slot[order[j]] = 12'(sh_uniques);
            for (int k = j + 1; k < order.size(); k++) begin
                if (sh_vtx[order[k]] != sh_vtx[order[j]]) break;
                if (merged[k] || !corners_weld(order[j], order[k], chans)) continue;
                merged[k] = 1'b1;
                sh_slot[order[k]] = 12'(sh_uniques);
            end
            sh_uniques++;
        end
        sh_computed = 1'b1;
    endfunction

    function automatic t_answer predict_answer(input logic [IN_W-1:0] beat);
        t_answer a;
        logic [2:0]  op;
        logic [11:0] idx;
        op = beat[2:0];
        idx = beat[303 +: 12];
        a.value = '0;
        a.err = 1'b0;
        case (op)
            OP_LOAD: begin
                if (sh_corners >= MAX_CORNERS) a.err = 1'b1;
                else begin
                    sh_vtx[sh_corners] = beat[3 +: 12];
                    sh_grp[sh_corners] = beat[15 +: 32];
                    sh_uv[sh_corners] = '0;
                    for (int t = 0; t < MAX_CHANNELS; t++) begin
                        sh_uv[sh_corners][64*t +: 32] = beat[47 + 64*t +: 32];
                        sh_uv[sh_corners][64*t+32 +: 32] = beat[79 + 64*t +: 32];
                    end
                    a.value = 13'(sh_corners);
                    sh_corners++;
                    sh_computed = 1'b0;
                end
            end
            OP_COMPUTE: begin
                weld_corners();
                a.value = 13'(sh_uniques);
            end
            OP_RDSLOT: begin
                if (!sh_computed || idx >= sh_corners) a.err = 1'b1;
                else a.value = 13'(sh_slot[idx]);
            end
            OP_RDREP: begin
                if (!sh_computed || idx >= sh_uniques) a.err = 1'b1;
                else a.value = 13'(sh_rep[idx]);
            end
            OP_CLEAR: begin
                sh_corners = 0;
                sh_uniques = 0;
                sh_computed = 1'b0;
            end
            default: ;
        endcase
        return a;
    endfunction

    // Gap of random length: mostly short, sometimes long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [IN_W-1:0] pack_beat(input logic [2:0] op,
        input logic [11:0] vtx, input logic [31:0] grp, input logic [255:0] uvs,
        input logic [11:0] idx);
        logic [IN_W-1:0] b;
        b = '0;
        b[2:0] = op;
        b[3 +: 12] = vtx;
        b[15 +: 32] = grp;
        b[47 +: 256] = uvs;
        b[303 +: 12] = idx;
        return b;
    endfunction

    // Send one beat and record its predicted answer.
    task automatic send_beat(input logic [IN_W-1:0] beat, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        repeat (gap) @(negedge i_clk);
        s_axis_tdata  = beat;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        answers_due.insert(answers_due.size(), predict_answer(beat));
        if (beat[2:0] == OP_COMPUTE) computes_sent++;
        beats_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_channels(input logic [2:0] value);
        drain();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sh_chans = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_load(input logic [11:0] vtx, input logic [31:0] grp,
                             input logic [255:0] uvs);
        send_beat(pack_beat(OP_LOAD, vtx, grp, uvs, 12'd0));
    endtask

    task automatic send_op(input logic [2:0] op, input logic [11:0] idx = 12'd0);
        send_beat(pack_beat(op, $urandom, $urandom, {8{$urandom}}, idx));
    endtask

    // Directed: reads before compute, empty compute, zero signs, NaN, extremes.
    task automatic test_directed();
        logic [255:0] uv;
        send_op(OP_RDSLOT, 12'd0);
        send_op(OP_RDREP, 12'd0);
        send_op(OP_COMPUTE);
        send_op(OP_RDREP, 12'd0);
        uv = '0;
        send_load(12'd5, 32'hFFFF_FFFF, uv);
        uv[31:0] = 32'h8000_0000;
        send_load(12'd5, 32'hFFFF_FFFF, uv);
        uv[31:0] = 32'h7FC0_0000;
        send_load(12'd5, 32'hFFFF_FFFF, uv);
        send_load(12'd5, 32'hFFFF_FFFF, uv);
        send_load(12'd4095, 32'd0, {8{32'hFFFF_FFFF}});
        send_load(12'd0, 32'd0, {8{32'h3F80_0000}});
        send_op(OP_RDSLOT, 12'd0);
        send_op(OP_COMPUTE);
        for (int i = 0; i < 7; i++) send_op(OP_RDSLOT, i);
        send_op(OP_RDREP, 12'd4);
        send_op(OP_RDREP, 12'd4095);
        send_op(3'd5);
        send_op(3'd7);
        send_op(OP_CLEAR);
        send_op(OP_RDSLOT, 12'd0);
    endtask

    // Small meshes built from a pool of shared corners so many of them weld.
    task automatic test_random_meshes(input int n_beats);
        logic [31:0]  grp_pool [4];
        logic [255:0] uv_pool  [4];
        logic [255:0] uv;
        int sent;
        int n_corners;
        sent = 0;
        while (sent < n_beats) begin
            if ($urandom_range(0, 5) == 0) write_channels($urandom_range(0, 7));
            foreach (grp_pool[p]) begin
                grp_pool[p] = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 3);
                uv_pool[p] = {8{$urandom}} ^ {$urandom, $urandom, $urandom, $urandom,
                                              $urandom, $urandom, $urandom, $urandom};
            end
            n_corners = $urandom_range(1, 12);
            for (int i = 0; i < n_corners; i++) begin
                uv = uv_pool[$urandom_range(0, 3)];
                // Occasionally perturb one coordinate, flip a zero sign or plant a NaN.
                case ($urandom_range(0, 7))
                    0: uv[$urandom_range(0, 255)] ^= 1'b1;
                    1: uv[32*$urandom_range(0, 7) +: 32] = 32'h8000_0000 * $urandom_range(0, 1);
                    2: uv[32*$urandom_range(0, 7) +: 32] = 32'h7F80_0001 | $urandom;
                    default: ;
                endcase
                send_load($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom,
                          grp_pool[$urandom_range(0, 3)], uv);
                sent++;
            end
            if ($urandom_range(0, 7) != 0) send_op(OP_COMPUTE);
            for (int r = 0; r < n_corners + 3; r++) begin
                send_op($urandom_range(0, 1) ? OP_RDSLOT : OP_RDREP,
                        $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, n_corners));
                sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_op($urandom_range(5, 7));
                sent++;
            end
            if ($urandom_range(0, 2) != 0) send_op(OP_CLEAR);
            sent += 2;
        end
        send_op(OP_CLEAR);
    endtask

    // Result checking at the rising edge.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_checked <= beats_checked + 1;
            if (answers_due.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = answers_due.pop_front();
                if (m_axis_tdata[12:0] !== want.value) begin
                    $error("result_value: expected %0d, got %0d", want.value,
                           m_axis_tdata[12:0]);
                    fail_count++;
                end
                if (m_axis_tdata[13] !== want.err) begin
                    $error("error_flag: expected %0d, got %0d", want.err, m_axis_tdata[13]);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls, with calm stretches.
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if ((beats_sent / 200) % 3 == 1) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 99) < 65) ||
                              ($urandom_range(0, 49) == 0 ? 1'b0 : 1'b0);
    end

    initial begin
        #400_000_000;
        $display("** mesh_vertex_welder_core: FAILED **");
        $finish;
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        sh_corners = 0;
        sh_uniques = 0;
        sh_computed = 1'b0;
        sh_chans = 3'd1;
        fail_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        computes_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        write_channels(3'd0);
        test_random_meshes(500);
        write_channels(3'd7);
        test_random_meshes(500);
        drain();
        $display("Sent %0d beats including %0d welds; checked %0d result beats.",
                 beats_sent, computes_sent, beats_checked);
        if (fail_count == 0 && answers_due.size() == 0)
            $display("** mesh_vertex_welder_core: PASSED **");
        else
            $display("** mesh_vertex_welder_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
src/mvw_pkg.sv
src/mvw_ctrl.sv
src/mvw_dp.sv
src/mesh_vertex_welder_core.sv
tb/sv/tb_mesh_vertex_welder_core.sv
